@@ src/stc_pkg.sv @@
// Package for the soil texture classifier: field widths, class codes and
// the twelve texture polygons in whole percents of (sand, clay).
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package stc_pkg;

   localparam int PCT_W       = 14;
   localparam int CLASS_W     = 4;
   localparam int NUM_CLASSES = 12;
   localparam int MAX_VERTS   = 8;
   localparam int VERT_W      = 7;
   localparam int PCT_SCALE   = 100;
   localparam int DIFF_W      = PCT_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;

   typedef logic [PCT_W-1:0]       pct_type;
   typedef logic [CLASS_W-1:0]     class_type;
   typedef logic [NUM_CLASSES-1:0] hit_type;
   typedef logic [VERT_W-1:0]      vert_type;

   localparam pct_type   FULL_SCALE = 14'd10000;
   localparam class_type CLASS_NONE = 4'd0;

   // vertex count per polygon, closing vertex included where listed
   localparam int POLY_N [NUM_CLASSES] = '{6, 4, 5, 4, 6, 5, 5, 7, 6, 4, 5, 8};

   // sand coordinate of each vertex, whole percent, unused slots zero
   localparam vert_type POLY_SX [NUM_CLASSES][MAX_VERTS] = '{
      '{7'd0,  7'd0,   7'd20, 7'd45, 7'd45, 7'd0,  7'd0,  7'd0 },
      '{7'd0,  7'd0,   7'd20, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0 },
      '{7'd0,  7'd0,   7'd20, 7'd20, 7'd0,  7'd0,  7'd0,  7'd0 },
      '{7'd45, 7'd45,  7'd65, 7'd45, 7'd0,  7'd0,  7'd0,  7'd0 },
      '{7'd45, 7'd45,  7'd52, 7'd80, 7'd65, 7'd45, 7'd0,  7'd0 },
      '{7'd20, 7'd20,  7'd45, 7'd45, 7'd20, 7'd0,  7'd0,  7'd0 },
      '{7'd0,  7'd0,   7'd20, 7'd8,  7'd0,  7'd0,  7'd0,  7'd0 },
      '{7'd8,  7'd20,  7'd50, 7'd23, 7'd0,  7'd0,  7'd8,  7'd0 },
      '{7'd23, 7'd43,  7'd52, 7'd52, 7'd45, 7'd23, 7'd0,  7'd0 },
      '{7'd85, 7'd100, 7'd90, 7'd85, 7'd0,  7'd0,  7'd0,  7'd0 },
      '{7'd70, 7'd85,  7'd90, 7'd85, 7'd70, 7'd0,  7'd0,  7'd0 },
      '{7'd43, 7'd50,  7'd70, 7'd85, 7'd80, 7'd52, 7'd52, 7'd43}
   };

   // clay coordinate of each vertex, whole percent, unused slots zero
   localparam vert_type POLY_CY [NUM_CLASSES][MAX_VERTS] = '{
      '{7'd100, 7'd60, 7'd40, 7'd40, 7'd55, 7'd100, 7'd0,  7'd0},
      '{7'd60,  7'd40, 7'd40, 7'd60, 7'd0,  7'd0,   7'd0,  7'd0},
      '{7'd40,  7'd27, 7'd27, 7'd40, 7'd40, 7'd0,   7'd0,  7'd0},
      '{7'd55,  7'd35, 7'd35, 7'd55, 7'd0,  7'd0,   7'd0,  7'd0},
      '{7'd35,  7'd27, 7'd20, 7'd20, 7'd35, 7'd35,  7'd0,  7'd0},
      '{7'd40,  7'd27, 7'd27, 7'd40, 7'd40, 7'd0,   7'd0,  7'd0},
      '{7'd12,  7'd0,  7'd0,  7'd12, 7'd12, 7'd0,   7'd0,  7'd0},
      '{7'd12,  7'd0,  7'd0,  7'd27, 7'd27, 7'd12,  7'd12, 7'd0},
      '{7'd27,  7'd7,  7'd7,  7'd20, 7'd27, 7'd27,  7'd0,  7'd0},
      '{7'd0,   7'd0,  7'd10, 7'd0,  7'd0,  7'd0,   7'd0,  7'd0},
      '{7'd0,   7'd0,  7'd10, 7'd15, 7'd0,  7'd0,   7'd0,  7'd0},
      '{7'd7,   7'd0,  7'd0,  7'd15, 7'd20, 7'd20,  7'd7,  7'd7}
   };

endpackage

`default_nettype wire

@@ src/stc_edge.sv @@
// One polygon edge of the crossing-number test: straddle check and exact
// cross-multiplied side test, all in hundredths of a percent.
// Depends on stc_pkg.
`default_nettype none

module stc_edge
   import stc_pkg::*;
(
   input  wire pct_type sand,
   input  wire pct_type clay,
   input  wire pct_type xi,
   input  wire pct_type yi,
   input  wire pct_type xj,
   input  wire pct_type yj,
   output logic         crossed
);

   logic                     straddle;
   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] ds;
   logic signed [DIFF_W-1:0] dc;
   logic signed [PROD_W-1:0] lhs;
   logic signed [PROD_W-1:0] rhs;
   logic                     left;

   // edge spans the clay value, half-open at the upper end
   assign straddle = ((yi <= clay) && (clay < yj)) || ((yj <= clay) && (clay < yi));

   // differences as signed values one bit wider than the coordinates
   assign dy = signed'({1'b0, yj})   - signed'({1'b0, yi});
   assign dx = signed'({1'b0, xj})   - signed'({1'b0, xi});
   assign ds = signed'({1'b0, sand}) - signed'({1'b0, xi});
   assign dc = signed'({1'b0, clay}) - signed'({1'b0, yi});

   assign lhs = PROD_W'(ds) * PROD_W'(dy);
   assign rhs = PROD_W'(dx) * PROD_W'(dc);

   // flip the comparison sense on a falling clay span
   assign left    = dy[DIFF_W-1] ? (lhs > rhs) : (lhs < rhs);
   assign crossed = straddle && left;

endmodule

`default_nettype wire

@@ src/stc_classify.sv @@
// Point-in-polygon tests for all twelve texture polygons at once; gives
// one hit bit per polygon. Depends on stc_pkg and stc_edge.
`default_nettype none

module stc_classify
   import stc_pkg::*;
(
   input  wire pct_type sand,
   input  wire pct_type clay,
   output hit_type      hit
);

   logic [MAX_VERTS-1:0] crossed [NUM_CLASSES];

   for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_poly
      for (genvar i = 0; i < MAX_VERTS; i++) begin : g_vert
         if (i < POLY_N[k]) begin : g_edge
            localparam int J = (i == 0) ? POLY_N[k] - 1 : i - 1;
            stc_edge u_edge (
               .sand    (sand),
               .clay    (clay),
               .xi      (PCT_W'(int'(POLY_SX[k][i]) * PCT_SCALE)),
               .yi      (PCT_W'(int'(POLY_CY[k][i]) * PCT_SCALE)),
               .xj      (PCT_W'(int'(POLY_SX[k][J]) * PCT_SCALE)),
               .yj      (PCT_W'(int'(POLY_CY[k][J]) * PCT_SCALE)),
               .crossed (crossed[k][i])
            );
         end else begin : g_none
            assign crossed[k][i] = 1'b0;
         end
      end
      // odd crossing count means inside
      assign hit[k] = ^crossed[k];
   end

endmodule

`default_nettype wire

@@ src/soil_texture_classifier.sv @@
// Pipeline: a word taken at a clock edge goes to the input registers, its
// class then to the class register, which drives rsp_* with rsp_valid.
// One word per cycle while busy is low; input and class registers overlap.
// Reset: synchronous; clears all valid flags and holds busy high for one
// cycle after reset drops. The receiver cannot stall, so busy never rises
// otherwise. Depends on stc_pkg, stc_classify.
`default_nettype none

module soil_texture_classifier
   import stc_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   output logic          busy,
   input  wire pct_type  req_sand_pct,
   input  wire pct_type  req_clay_pct,
   output logic          rsp_valid,
   output class_type     rsp_texture_class
);

   logic      busy_ff;
   logic      accept;
   logic      vld1_ff, vld2_ff;
   pct_type   sand_ff, sand_in;
   pct_type   clay_ff, clay_in;
   hit_type   hit_in;
   class_type class_ff, class_in;

   assign accept = start && !busy_ff;

   // saturate inputs above full scale
   assign sand_in = (req_sand_pct > FULL_SCALE) ? FULL_SCALE : req_sand_pct;
   assign clay_in = (req_clay_pct > FULL_SCALE) ? FULL_SCALE : req_clay_pct;

   stc_classify u_classify (
      .sand (sand_ff),
      .clay (clay_ff),
      .hit  (hit_in)
   );

   // take the highest-numbered matching class
   always_comb begin
      class_in = CLASS_NONE;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         if (hit_in[k]) begin
            class_in = CLASS_W'(k + 1);
         end
      end
   end

   // control: valid flags and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
      end
   end

   // payload: inputs load on accept, class register advances every cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         sand_ff <= sand_in;
         clay_ff <= clay_in;
      end
      class_ff <= class_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = vld2_ff;
   assign rsp_texture_class = class_ff;

endmodule

`default_nettype wire

@@ src/stc_checker.sv @@
// Port-level checks for the soil texture classifier, bound to the top level.
// Depends on stc_pkg.
`default_nettype none

module stc_checker
   import stc_pkg::*;
(
   input wire            clock,
   input wire            reset,
   input wire            start,
   input wire            busy,
   input wire            rsp_valid,
   input wire class_type rsp_texture_class
);

   // each accepted word yields a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after accept");

   // no result without a matching accepted word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without matching accept");

   // class code stays within the defined classes
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_texture_class <= 4'(NUM_CLASSES)))
      else $error("texture class out of range");

   // busy only in the cycle right after reset
   a_busy_reset: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside reset recovery");

endmodule

bind soil_texture_classifier stc_checker u_checker (.*);

`default_nettype wire
